/* src/far_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_pkg: shared types and constants for the fraction add and reduce block
// Holds the default operand width, the sequencer state type and the control
// word handed to the serial divider.
// ----------------------------------------------------------------------------
package far_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SIGN,
      ST_SUM,
      ST_ABS,
      ST_GCD,
      ST_SCALE,
      ST_DIV_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

/* src/far_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_div: bit-serial restoring divider
// Loads a dividend, then produces one quotient bit per step, most significant
// first. After WIDTH steps the quotient register holds dividend / divisor.
// ----------------------------------------------------------------------------
module far_div #(
   parameter int WIDTH = 2 * far_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                 clock,
   input  far_pkg::div_ctl_type ctl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output logic [WIDTH-1:0]     quotient
);

   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] rem_in;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] quo_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (ctl.step) begin
         // keep the trial difference only when it did not borrow
         rem_in = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

/* src/fraction_add_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_reduce: adds two signed fractions and reduces the sum
// Forms n = a1*b2 + b1*a2 and d = b1*b2, divides both by gcd(|n|,|d|) and
// returns them with their signs as computed; d = 0 gives a flag and 0/0.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word goes through shift-add
// multiplication (three serial multipliers side by side), sign, add and
// magnitude steps, binary GCD steps, one step per common factor of two to
// rebuild the divisor, division in two parallel restoring dividers and a
// hand-off to the output register. A zero numerator or zero denominator
// skips the GCD and division. The input side opens again as soon as the
// result sits in the output register.
// ----------------------------------------------------------------------------
module fraction_add_reduce #(
   parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [OPERAND_WIDTH-1:0]   req_first_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_first_denominator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_second_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_second_denominator,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [2*OPERAND_WIDTH:0]   rsp_sum_numerator,
   output logic signed [2*OPERAND_WIDTH-1:0] rsp_sum_denominator,
   output logic                              rsp_zero_denominator
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int NW = PW + 1;
   localparam int CW = $clog2(PW + 1);

   far_pkg::state_type   state_ff;
   far_pkg::state_type   state_in;
   far_pkg::div_ctl_type div_ctl;
   logic                 accept;
   logic                 fin_load;
   logic                 mul_last;
   logic                 div_last;
   logic                 gcd_done;

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] k_ff;
   logic [W-1:0]  mca_ff;
   logic [W-1:0]  mcb_ff;
   logic [PW-1:0] p1_ff;
   logic [PW-1:0] p2_ff;
   logic [PW-1:0] p3_ff;
   logic          neg1_ff;
   logic          neg2_ff;
   logic          dneg_ff;
   logic          dzero_ff;
   logic          nzero_ff;
   logic [NW-1:0] t1_ff;
   logic [NW-1:0] t2_ff;
   logic [NW-1:0] n_ff;
   logic [PW-1:0] magn_ff;
   logic [PW-1:0] x_ff;
   logic [PW-1:0] y_ff;
   logic          rsp_valid_ff;
   logic [NW-1:0] rsp_num_ff;
   logic [PW-1:0] rsp_den_ff;
   logic          rsp_zero_ff;

   logic [W-1:0]  abs_a1;
   logic [W-1:0]  abs_b1;
   logic [W-1:0]  abs_a2;
   logic [W-1:0]  abs_b2;
   logic [W:0]    sum1;
   logic [W:0]    sum2;
   logic [W:0]    sum3;
   logic [NW-1:0] n_abs;
   logic [PW:0]   diff_xy;
   logic [PW:0]   diff_yx;
   logic [PW-1:0] q_n;
   logic [PW-1:0] q_d;
   logic [NW-1:0] num_out;
   logic [PW-1:0] den_out;

   // ---------------------------------------------------------------- control
   always_comb begin
      accept   = (state_ff == far_pkg::ST_IDLE) && req_valid;
      mul_last = (cnt_ff == CW'(W - 1));
      div_last = (cnt_ff == CW'(PW));
      gcd_done = (x_ff == y_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         far_pkg::ST_IDLE: begin
            if (req_valid) state_in = far_pkg::ST_MUL;
         end
         far_pkg::ST_MUL: begin
            if (mul_last) state_in = far_pkg::ST_SIGN;
         end
         far_pkg::ST_SIGN: state_in = far_pkg::ST_SUM;
         far_pkg::ST_SUM:  state_in = far_pkg::ST_ABS;
         far_pkg::ST_ABS: begin
            if (dzero_ff || (n_ff == '0)) state_in = far_pkg::ST_DIV_FIN;
            else state_in = far_pkg::ST_GCD;
         end
         far_pkg::ST_GCD: begin
            if (gcd_done) state_in = far_pkg::ST_SCALE;
         end
         far_pkg::ST_SCALE: begin
            if (k_ff == '0) state_in = far_pkg::ST_DIV_FIN;
         end
         far_pkg::ST_DIV_FIN: begin
            if (fin_load) state_in = far_pkg::ST_IDLE;
         end
         default: state_in = far_pkg::ST_IDLE;
      endcase
   end

   // the divide phase and the final hand-off share one state: the counter
   // runs the divider until its last step, then the word waits for the output
   always_comb begin
      req_ready    = (state_ff == far_pkg::ST_IDLE);
      div_ctl.load = (state_ff == far_pkg::ST_SCALE) && (k_ff == '0);
      div_ctl.step = (state_ff == far_pkg::ST_DIV_FIN) && !div_last && !nzero_ff
                     && !dzero_ff;
      fin_load     = (state_ff == far_pkg::ST_DIV_FIN)
                     && (div_last || nzero_ff || dzero_ff)
                     && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= far_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // --------------------------------------------------------------- datapath
   always_comb begin
      abs_a1 = req_first_numerator[W-1]    ? W'(-req_first_numerator)
                                           : req_first_numerator;
      abs_b1 = req_first_denominator[W-1]  ? W'(-req_first_denominator)
                                           : req_first_denominator;
      abs_a2 = req_second_numerator[W-1]   ? W'(-req_second_numerator)
                                           : req_second_numerator;
      abs_b2 = req_second_denominator[W-1] ? W'(-req_second_denominator)
                                           : req_second_denominator;
      sum1 = {1'b0, p1_ff[PW-1:W]} + (p1_ff[0] ? {1'b0, mca_ff} : '0);
      sum2 = {1'b0, p2_ff[PW-1:W]} + (p2_ff[0] ? {1'b0, mcb_ff} : '0);
      sum3 = {1'b0, p3_ff[PW-1:W]} + (p3_ff[0] ? {1'b0, mcb_ff} : '0);
      n_abs   = n_ff[NW-1] ? (NW'(0) - n_ff) : n_ff;
      diff_xy = {1'b0, x_ff} - {1'b0, y_ff};
      diff_yx = {1'b0, y_ff} - {1'b0, x_ff};
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         far_pkg::ST_IDLE: begin
            cnt_ff <= '0;
            if (accept) begin
               mca_ff  <= abs_a1;
               mcb_ff  <= abs_b1;
               p1_ff   <= {{W{1'b0}}, abs_b2};
               p2_ff   <= {{W{1'b0}}, abs_a2};
               p3_ff   <= {{W{1'b0}}, abs_b2};
               neg1_ff <= req_first_numerator[W-1] ^ req_second_denominator[W-1];
               neg2_ff <= req_first_denominator[W-1] ^ req_second_numerator[W-1];
               dneg_ff <= req_first_denominator[W-1] ^ req_second_denominator[W-1];
            end
         end
         far_pkg::ST_MUL: begin
            // shift-add: one multiplier bit per cycle, low bits retire right
            p1_ff  <= {sum1, p1_ff[W-1:1]};
            p2_ff  <= {sum2, p2_ff[W-1:1]};
            p3_ff  <= {sum3, p3_ff[W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
         end
         far_pkg::ST_SIGN: begin
            cnt_ff   <= '0;
            t1_ff    <= neg1_ff ? (NW'(0) - {1'b0, p1_ff}) : {1'b0, p1_ff};
            t2_ff    <= neg2_ff ? (NW'(0) - {1'b0, p2_ff}) : {1'b0, p2_ff};
            dzero_ff <= (p3_ff == '0);
         end
         far_pkg::ST_SUM: begin
            cnt_ff <= '0;
            n_ff   <= t1_ff + t2_ff;
         end
         far_pkg::ST_ABS: begin
            cnt_ff   <= '0;
            magn_ff  <= n_abs[PW-1:0];
            x_ff     <= n_abs[PW-1:0];
            y_ff     <= p3_ff;
            k_ff     <= '0;
            nzero_ff <= (n_ff == '0);
         end
         far_pkg::ST_GCD: begin
            cnt_ff <= '0;
            if (!gcd_done) begin
               if (!x_ff[0] && !y_ff[0]) begin
                  x_ff <= x_ff >> 1;
                  y_ff <= y_ff >> 1;
                  k_ff <= k_ff + 1'b1;
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (!diff_xy[PW]) begin
                  x_ff <= diff_xy[PW-1:0];
               end else begin
                  y_ff <= diff_yx[PW-1:0];
               end
            end
         end
         far_pkg::ST_SCALE: begin
            cnt_ff <= '0;
            // restore the common factors of two into the divisor
            if (k_ff != '0) begin
               x_ff <= x_ff << 1;
               k_ff <= k_ff - 1'b1;
            end
         end
         far_pkg::ST_DIV_FIN: begin
            if (div_ctl.step) cnt_ff <= cnt_ff + 1'b1;
            else cnt_ff <= cnt_ff;
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   far_div #(
      .WIDTH (PW)
   ) u_div_num (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (magn_ff),
      .divisor  (x_ff),
      .quotient (q_n)
   );

   far_div #(
      .WIDTH (PW)
   ) u_div_den (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (p3_ff),
      .divisor  (x_ff),
      .quotient (q_d)
   );

   always_comb begin
      if (dzero_ff) begin
         num_out = '0;
         den_out = '0;
      end else if (nzero_ff) begin
         num_out = '0;
         den_out = dneg_ff ? '1 : PW'(1);
      end else begin
         num_out = n_ff[NW-1] ? (NW'(0) - {1'b0, q_n}) : {1'b0, q_n};
         den_out = dneg_ff ? (PW'(0) - q_d) : q_d;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_num_ff  <= num_out;
         rsp_den_ff  <= den_out;
         rsp_zero_ff <= dzero_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sum_numerator    = rsp_num_ff;
   assign rsp_sum_denominator  = rsp_den_ff;
   assign rsp_zero_denominator = rsp_zero_ff;

endmodule

/* test/tb_fraction_add_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_add_reduce: self-checking bench for the fraction adder/reducer
// Drives a short table of hand-picked fraction pairs, then several hundred
// random pairs, with random gaps on the request side and random back-pressure
// on the response side. Every response word is compared field by field with
// an in-order queue of sums from the table or from a behavioral model in this file.
// ----------------------------------------------------------------------------
module tb_fraction_add_reduce;

   localparam int W            = far_pkg::OPERAND_WIDTH_DEF;
   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 5_000_000;

   typedef struct packed {
      logic signed [2*W:0]   num;
      logic signed [2*W-1:0] den;
      logic                  zero;
   } sum_type;

   typedef struct packed {
      logic signed [W-1:0] a1;
      logic signed [W-1:0] b1;
      logic signed [W-1:0] a2;
      logic signed [W-1:0] b2;
      logic                typed;
      sum_type             want;
   } stim_row_type;

   // a1, b1, a2, b2, typed, {num, den, zero}; untyped rows go to the model
   localparam int NUM_ROWS = 22;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{0, 1, 0, 1, 1'b1, '{0, 1, 0}},
      '{0, -1, 0, 1, 1'b1, '{0, -1, 0}},
      '{1, 0, 1, 1, 1'b1, '{0, 0, 1}},
      '{5, 3, 7, 0, 1'b1, '{0, 0, 1}},
      '{0, 0, 0, 0, 1'b1, '{0, 0, 1}},
      '{-32768, -32768, -32768, -32768, 1'b1, '{2, 1, 0}},
      '{32767, 32767, 32767, 32767, 1'b1, '{2, 1, 0}},
      '{32767, 1, 32767, 1, 1'b1, '{65534, 1, 0}},
      '{-32768, 1, -32768, 1, 1'b1, '{-65536, 1, 0}},
      '{1, -1, 1, 1, 1'b1, '{0, -1, 0}},
      '{1, 2, -1, 2, 1'b1, '{0, 1, 0}},
      '{1, 2, 1, 3, 1'b1, '{5, 6, 0}},
      '{-1, 2, 1, -3, 1'b1, '{5, -6, 0}},
      '{3, 4, 1, 4, 1'b1, '{1, 1, 0}},
      '{32767, 32767, -32768, -32768, 1'b1, '{-2, -1, 0}},
      '{-1, -1, -1, -1, 1'b1, '{2, 1, 0}},
      '{32767, -32768, 32767, -32768, 1'b0, '{0, 0, 0}},
      '{12345, -23456, -31111, 29999, 1'b0, '{0, 0, 0}},
      '{-32768, 32767, 32767, -32768, 1'b0, '{0, 0, 0}},
      '{1, 32767, 1, -32768, 1'b0, '{0, 0, 0}},
      '{21845, 10922, 10922, 21845, 1'b0, '{0, 0, 0}},
      '{-21846, -10923, -10923, -21846, 1'b0, '{0, 0, 0}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [W-1:0]   req_first_numerator = '0;
   logic signed [W-1:0]   req_first_denominator = '0;
   logic signed [W-1:0]   req_second_numerator = '0;
   logic signed [W-1:0]   req_second_denominator = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [2*W:0]   rsp_sum_numerator;
   logic signed [2*W-1:0] rsp_sum_denominator;
   logic                  rsp_zero_denominator;

   sum_type     pending_sums [$];
   sum_type     oldest_sum;
   int unsigned words_sent = 0;
   int unsigned sums_checked = 0;
   int unsigned zero_den_sums = 0;
   int unsigned zero_num_sums = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          calm = 1'b0;

   fraction_add_reduce #(
      .OPERAND_WIDTH(W)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_first_numerator   (req_first_numerator),
      .req_first_denominator (req_first_denominator),
      .req_second_numerator  (req_second_numerator),
      .req_second_denominator(req_second_denominator),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sum_numerator     (rsp_sum_numerator),
      .rsp_sum_denominator   (rsp_sum_denominator),
      .rsp_zero_denominator  (rsp_zero_denominator)
   );

   always #5 clock = ~clock;

   // Sum over the cross-multiplied denominator, reduced by gcd(|n|,|d|).
   function automatic sum_type reduce_sum(input logic signed [W-1:0] a1, b1, a2, b2);
      longint            n;
      longint            d;
      longint unsigned   mag_n;
      longint unsigned   mag_d;
      longint unsigned   x;
      longint unsigned   y;
      longint unsigned   r;
      sum_type           s;
      n = longint'(a1) * longint'(b2) + longint'(b1) * longint'(a2);
      d = longint'(b1) * longint'(b2);
      s = '0;
      if (d == 0) begin
         s.zero = 1'b1;
      end else if (n == 0) begin
         s.den = (d < 0) ? (2*W)'(-1) : (2*W)'(1);
      end else begin
         mag_n = (n < 0) ? -n : n;
         mag_d = (d < 0) ? -d : d;
         x = mag_n;
         y = mag_d;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         s.num = (2*W+1)'((n < 0) ? -longint'(mag_n / x) : longint'(mag_n / x));
         s.den = (2*W)'((d < 0) ? -longint'(mag_d / x) : longint'(mag_d / x));
      end
      return s;
   endfunction

   // Mostly zero or short, now and then a long stretch.
   function automatic int unsigned idle_len(input int unsigned long_pct);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < long_pct) return $urandom_range(20, 300);
      if (pick < 50) return $urandom_range(1, 4);
      return 0;
   endfunction

   // Full-range values, small values (reducible, zeros), extremes, scaled powers of two.
   function automatic logic signed [W-1:0] draw_operand();
      int unsigned pick;
      int          v;
      pick = $urandom_range(0, 99);
      if (pick < 45) return W'($urandom);
      if (pick < 75) return W'(int'($urandom_range(0, 40)) - 20);
      if (pick < 90) begin
         case ($urandom_range(0, 5))
            0:       return {1'b1, {(W-1){1'b0}}};
            1:       return {1'b0, {(W-1){1'b1}}};
            2:       return '1;
            3:       return W'(1);
            4:       return W'(0);
            default: return {1'b1, {(W-2){1'b0}}, 1'b1};
         endcase
      end
      v = int'($urandom_range(1, 15)) << $urandom_range(0, W-5);
      return W'($urandom_range(0, 1) ? -v : v);
   endfunction

   task automatic send_word(input logic signed [W-1:0] a1, b1, a2, b2,
                            input bit typed, input sum_type want, input bit last);
      sum_type     sum;
      int unsigned gap;
      req_valid              <= 1'b1;
      req_first_numerator    <= a1;
      req_first_denominator  <= b1;
      req_second_numerator   <= a2;
      req_second_denominator <= b2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sum = typed ? want : reduce_sum(a1, b1, a2, b2);
      pending_sums.push_back(sum);
      words_sent++;
      gap = calm ? 0 : idle_len(8);
      // drop valid after the final word as well
      if (gap > 0 || last) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side back-pressure.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) hold_left <= idle_len(3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: %0d/%0d zero=%0b",
                        rsp_sum_numerator, rsp_sum_denominator, rsp_zero_denominator);
         end else begin
            oldest_sum = pending_sums.pop_front();
            if (rsp_sum_numerator !== oldest_sum.num
                || rsp_sum_denominator !== oldest_sum.den
                || rsp_zero_denominator !== oldest_sum.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected %0d/%0d zero=%0b, got %0d/%0d zero=%0b",
                           sums_checked, oldest_sum.num, oldest_sum.den, oldest_sum.zero,
                           rsp_sum_numerator, rsp_sum_denominator, rsp_zero_denominator);
            end
            if (oldest_sum.zero) zero_den_sums++;
            else if (oldest_sum.num == 0) zero_num_sums++;
            sums_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending",
                  cycle_count, pending_sums.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++)
         send_word(DIRECTED_ROWS[i].a1, DIRECTED_ROWS[i].b1, DIRECTED_ROWS[i].a2,
                   DIRECTED_ROWS[i].b2, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want,
                   1'b0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // switch between idle-free stretches and gappy ones
         if (i % 80 == 0) calm = ($urandom_range(0, 3) == 0);
         send_word(draw_operand(), draw_operand(), draw_operand(), draw_operand(),
                   1'b0, '0, i == RANDOM_WORDS - 1);
      end
      calm = 1'b0;

      while (pending_sums.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d fraction pairs, checked %0d sums in %0d cycles",
               words_sent, sums_checked, cycle_count);
      $display("zero-denominator sums: %0d, zero-numerator sums: %0d, mismatches: %0d",
               zero_den_sums, zero_num_sums, mismatches);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
